// File: sv/tet_pkg.sv
`timescale 1ns / 1ps

package tet_pkg;

	localparam int unsigned MAX_POINTS = 2;
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;
	localparam int unsigned MID_DEPTH  = 2;
	localparam int unsigned OUT_DEPTH  = 2;

	localparam logic [11:0] RESET_WIDTH  = 12'd480;
	localparam logic [11:0] RESET_HEIGHT = 12'd320;
	localparam logic [1:0]  RESET_ROT    = 2'd0;
	localparam logic [7:0]  RESET_PERIOD = 8'd5;
	localparam logic [3:0]  COUNT_MASK   = 4'hF;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd3;

	localparam logic CMD_IRQ  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_DOWN = 2'd1;
	localparam logic [1:0] EV_MOVE = 2'd2;
	localparam logic [1:0] EV_UP   = 2'd3;

	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_90   = 2'd1;
	localparam logic [1:0] ROT_180  = 2'd2;
	localparam logic [1:0] ROT_270  = 2'd3;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic       command;
		logic       read_ok;
		logic [7:0] status_byte;
		logic [7:0] first_x_high;
		logic [7:0] first_x_low;
		logic [7:0] first_y_high;
		logic [7:0] first_y_low;
		logic [7:0] second_x_high;
		logic [7:0] second_x_low;
		logic [7:0] second_y_high;
		logic [7:0] second_y_low;
	} raw_t;

	typedef struct packed {
		coord_t     width;
		coord_t     height;
		logic [1:0] rotation;
	} map_cfg_t;

	// decoded transaction handed from front to back
	typedef struct packed {
		logic       command;
		logic       read_ok;
		logic [1:0] count;
		coord_t     p0_x;
		coord_t     p0_y;
		coord_t     p1_x;
		coord_t     p1_y;
	} item_t;

	typedef struct packed {
		logic [1:0] event_kind;
		coord_t     event_x;
		coord_t     event_y;
		logic [1:0] active_touches;
		coord_t     other_x;
		coord_t     other_y;
		logic       link_ok;
		logic       held_pressed;
	} result_t;

endpackage

// File: sv/tet_fifo.sv
`timescale 1ns / 1ps

module tet_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rd_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/tet_front.sv
`timescale 1ns / 1ps

module tet_front import tet_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  raw_t     raw,
	input  map_cfg_t map_cfg,
	output logic     q_push,
	input  logic     q_full,
	output item_t    q_item
);

	logic  s1_valid_q;
	item_t item_s1;
	logic  take;
	logic  accept;
	item_t decoded;
	coord_t p0_raw_x, p0_raw_y, p1_raw_x, p1_raw_y;
	coord_t p0_mx, p0_my, p1_mx, p1_my;
	logic [3:0] raw_cnt;
	logic [1:0] cnt;

	function automatic coord_t map_axis(input logic signed [13:0] v, input coord_t lim);
		logic signed [13:0] lim_s;
		lim_s = $signed({2'b00, lim});
		if (v < 14'sd0) begin
			return '0;
		end else if (v >= lim_s) begin
			return lim - 1'b1;
		end else begin
			return v[11:0];
		end
	endfunction

	function automatic logic [23:0] map_point(input coord_t rx, input coord_t ry,
			input map_cfg_t c);
		logic signed [13:0] sx, sy, wm1, hm1, mx, my;
		sx  = $signed({2'b00, rx});
		sy  = $signed({2'b00, ry});
		wm1 = $signed({2'b00, c.width}) - 14'sd1;
		hm1 = $signed({2'b00, c.height}) - 14'sd1;
		unique case (c.rotation)
			ROT_90: begin
				mx = sy;
				my = hm1 - sx;
			end
			ROT_180: begin
				mx = wm1 - sx;
				my = hm1 - sy;
			end
			ROT_270: begin
				mx = wm1 - sy;
				my = sx;
			end
			default: begin
				mx = sx;
				my = sy;
			end
		endcase
		if (c.width == '0 || c.height == '0) begin
			return '0;
		end
		return {map_axis(mx, c.width), map_axis(my, c.height)};
	endfunction

	assign p0_raw_x = {raw.first_x_high[3:0], raw.first_x_low};
	assign p0_raw_y = {raw.first_y_high[3:0], raw.first_y_low};
	assign p1_raw_x = {raw.second_x_high[3:0], raw.second_x_low};
	assign p1_raw_y = {raw.second_y_high[3:0], raw.second_y_low};
	assign raw_cnt  = raw.status_byte[3:0] & COUNT_MASK;
	assign cnt      = (raw_cnt > 4'(MAX_POINTS)) ? 2'(MAX_POINTS) : raw_cnt[1:0];

	assign {p0_mx, p0_my} = map_point(p0_raw_x, p0_raw_y, map_cfg);
	assign {p1_mx, p1_my} = map_point(p1_raw_x, p1_raw_y, map_cfg);

	always_comb begin
		decoded         = '0;
		decoded.command = raw.command;
		decoded.read_ok = raw.read_ok;
		decoded.count   = cnt;
		if (cnt >= 2'd1) begin
			decoded.p0_x = p0_mx;
			decoded.p0_y = p0_my;
		end
		if (cnt >= 2'd2) begin
			decoded.p1_x = p1_mx;
			decoded.p1_y = p1_my;
		end
	end

	assign take   = ~s1_valid_q | ~q_full;
	assign accept = push & take;
	assign full   = ~take;
	assign q_push = s1_valid_q;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept | (s1_valid_q & q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= decoded;
		end
	end

endmodule

// File: sv/tet_back.sv
`timescale 1ns / 1ps

module tet_back import tet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] idle_period,
	input  logic       q_empty,
	input  item_t      q_item,
	output logic       q_pop,
	input  logic       out_full,
	output logic       out_push,
	output result_t    out_result
);

	logic       irq_pending_q, tracking_q, last_pressed_q, comm_good_q;
	coord_t     last_x_q, last_y_q, other_x_q, other_y_q;
	logic [7:0] idle_div_q;
	logic [1:0] total_q;

	logic       irq_pending_n, tracking_n, last_pressed_n, comm_good_n;
	coord_t     last_x_n, last_y_n, other_x_n, other_y_n;
	logic [7:0] idle_div_n, div_inc;
	logic [1:0] total_n;
	logic       scan;
	logic       fire;
	result_t    res;

	assign fire     = ~q_empty & ~out_full;
	assign q_pop    = fire;
	assign out_push = fire;
	assign div_inc  = idle_div_q + 8'd1;

	always_comb begin
		irq_pending_n  = irq_pending_q;
		tracking_n     = tracking_q;
		last_pressed_n = last_pressed_q;
		comm_good_n    = comm_good_q;
		last_x_n       = last_x_q;
		last_y_n       = last_y_q;
		other_x_n      = other_x_q;
		other_y_n      = other_y_q;
		idle_div_n     = idle_div_q;
		total_n        = total_q;
		scan           = 1'b0;
		res            = '0;
		res.event_kind = EV_NONE;
		if (q_item.command == CMD_IRQ) begin
			irq_pending_n = 1'b1;
			idle_div_n    = '0;
		end else begin
			scan = irq_pending_q | tracking_q;
			if (!scan) begin
				if (div_inc >= idle_period) begin
					idle_div_n = '0;
					scan       = 1'b1;
				end else begin
					idle_div_n = div_inc;
				end
			end
			if (scan) begin
				irq_pending_n = 1'b0;
				total_n       = '0;
				other_x_n     = '0;
				other_y_n     = '0;
				if (!q_item.read_ok) begin
					comm_good_n = 1'b0;
				end else begin
					comm_good_n = 1'b1;
					total_n     = q_item.count;
					other_x_n   = q_item.p1_x;
					other_y_n   = q_item.p1_y;
					priority if (q_item.count != '0 && !tracking_q) begin
						tracking_n     = 1'b1;
						last_x_n       = q_item.p0_x;
						last_y_n       = q_item.p0_y;
						last_pressed_n = 1'b1;
						res.event_kind = EV_DOWN;
						res.event_x    = q_item.p0_x;
						res.event_y    = q_item.p0_y;
					end else if (q_item.count != '0) begin
						if (q_item.p0_x != last_x_q || q_item.p0_y != last_y_q) begin
							res.event_kind = EV_MOVE;
							res.event_x    = q_item.p0_x;
							res.event_y    = q_item.p0_y;
						end
						last_x_n       = q_item.p0_x;
						last_y_n       = q_item.p0_y;
						last_pressed_n = 1'b1;
					end else if (tracking_q) begin
						res.event_kind = EV_UP;
						res.event_x    = last_x_q;
						res.event_y    = last_y_q;
						tracking_n     = 1'b0;
						last_pressed_n = 1'b0;
					end else begin
						// no touch and nothing tracked: state kept
					end
				end
			end
		end
		res.active_touches = total_n;
		res.other_x        = other_x_n;
		res.other_y        = other_y_n;
		res.link_ok        = comm_good_n;
		res.held_pressed   = last_pressed_n;
	end

	assign out_result = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_pending_q  <= 1'b1;
			tracking_q     <= 1'b0;
			last_pressed_q <= 1'b0;
			comm_good_q    <= 1'b0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			other_x_q      <= '0;
			other_y_q      <= '0;
			idle_div_q     <= '0;
			total_q        <= '0;
		end else if (fire) begin
			irq_pending_q  <= irq_pending_n;
			tracking_q     <= tracking_n;
			last_pressed_q <= last_pressed_n;
			comm_good_q    <= comm_good_n;
			last_x_q       <= last_x_n;
			last_y_q       <= last_y_n;
			other_x_q      <= other_x_n;
			other_y_q      <= other_y_n;
			idle_div_q     <= idle_div_n;
			total_q        <= total_n;
		end
	end

endmodule

// File: sv/touch_event_tracker.sv
`timescale 1ns / 1ps
// Path: front register, mid queue, back stage, then output queue, whose empty goes low.
// Throughput: one transaction per cycle while no queue is full; the back stage updates
// the tracking state of one item per cycle, decoupled from the front by a short queue.
// Reset (arst_n low): configuration returns to 480 x 320, no rotation, poll period 5;
// interrupt pending set, tracking, stored points and link status cleared, queues emptied.
module touch_event_tracker import tet_pkg::*; #(
	parameter int unsigned MID_Q_DEPTH = MID_DEPTH,
	parameter int unsigned OUT_Q_DEPTH = OUT_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  command,
	input  logic                  read_ok,
	input  logic [7:0]            status_byte,
	input  logic [7:0]            first_x_high,
	input  logic [7:0]            first_x_low,
	input  logic [7:0]            first_y_high,
	input  logic [7:0]            first_y_low,
	input  logic [7:0]            second_x_high,
	input  logic [7:0]            second_x_low,
	input  logic [7:0]            second_y_high,
	input  logic [7:0]            second_y_low,
	output logic                  empty,
	input  logic                  pop,
	output logic [1:0]            event_kind,
	output logic [11:0]           event_x,
	output logic [11:0]           event_y,
	output logic [1:0]            active_touches,
	output logic [11:0]           other_x,
	output logic [11:0]           other_y,
	output logic                  link_ok,
	output logic                  held_pressed,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	coord_t     width_q, height_q;
	logic [1:0] rotation_q;
	logic [7:0] period_q;

	raw_t     raw;
	map_cfg_t map_cfg;
	logic     mid_push, mid_full, mid_pop, mid_empty;
	item_t    mid_wr, mid_rd;
	logic     out_push, out_full;
	result_t  out_wr, out_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RESET_WIDTH;
			height_q   <= RESET_HEIGHT;
			rotation_q <= RESET_ROT;
			period_q   <= RESET_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q    <= cfg_data[11:0];
				REG_HEIGHT: height_q   <= cfg_data[11:0];
				REG_ROT:    rotation_q <= cfg_data[1:0];
				REG_PERIOD: period_q   <= cfg_data[7:0];
				default:    ;
			endcase
		end
	end

	assign raw = '{
		command:       command,
		read_ok:       read_ok,
		status_byte:   status_byte,
		first_x_high:  first_x_high,
		first_x_low:   first_x_low,
		first_y_high:  first_y_high,
		first_y_low:   first_y_low,
		second_x_high: second_x_high,
		second_x_low:  second_x_low,
		second_y_high: second_y_high,
		second_y_low:  second_y_low
	};

	assign map_cfg = '{width: width_q, height: height_q, rotation: rotation_q};

	tet_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.raw     (raw),
		.map_cfg (map_cfg),
		.q_push  (mid_push),
		.q_full  (mid_full),
		.q_item  (mid_wr)
	);

	tet_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (MID_Q_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_push),
		.full    (mid_full),
		.wr_data (mid_wr),
		.pop     (mid_pop),
		.empty   (mid_empty),
		.rd_data (mid_rd)
	);

	tet_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.idle_period (period_q),
		.q_empty     (mid_empty),
		.q_item      (mid_rd),
		.q_pop       (mid_pop),
		.out_full    (out_full),
		.out_push    (out_push),
		.out_result  (out_wr)
	);

	tet_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_Q_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (out_push),
		.full    (out_full),
		.wr_data (out_wr),
		.pop     (pop),
		.empty   (empty),
		.rd_data (out_rd)
	);

	assign event_kind     = out_rd.event_kind;
	assign event_x        = out_rd.event_x;
	assign event_y        = out_rd.event_y;
	assign active_touches = out_rd.active_touches;
	assign other_x        = out_rd.other_x;
	assign other_y        = out_rd.other_y;
	assign link_ok        = out_rd.link_ok;
	assign held_pressed   = out_rd.held_pressed;

endmodule
